[design/slca_pkg.sv]
// ============================================================================
// slca_pkg
// Shared types and constants for the sparse linear classifier.
// ============================================================================
package slca_pkg;

    localparam int NUM_FEATURES_DEF = 1024;
    localparam int NUM_CLASSES_DEF  = 16;
    localparam int VALUE_BITS_DEF   = 16;

    localparam int FEAT_W  = 10;
    localparam int CLASS_W = 4;
    localparam int CFG_W   = 5;
    localparam int CNT_W   = 24;
    localparam int SCORE_W = 42;
    localparam int QDEPTH  = 2;

    localparam logic [CFG_W-1:0] CLASSES_RESET = 5'd16;
    localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // command handed from front to back
    typedef struct packed {
        t_op                op;
        logic               feat_ok;
        logic [FEAT_W-1:0]  feat;
        logic [CLASS_W-1:0] cls;
        logic [15:0]        wval;
        logic [15:0]        fval;
        logic [CLASS_W-1:0] label;
        logic               last;
    } t_cmd;

endpackage

[design/slca_if.sv]
// ============================================================================
// slca_in_if / slca_out_if
// Valid/ready channels carrying one input beat or one result beat.
// ============================================================================
interface slca_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [9:0]  feature_index;
    logic [3:0]  class_index;
    logic signed [15:0] weight_value;
    logic signed [15:0] feature_value;
    logic [3:0]  label;
    logic        last_feature;

    modport source (output valid, operation, feature_index, class_index,
                    weight_value, feature_value, label, last_feature,
                    input ready);
    modport sink (input valid, operation, feature_index, class_index,
                  weight_value, feature_value, label, last_feature,
                  output ready);
endinterface

interface slca_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  predicted_class;
    logic        is_correct;
    logic [23:0] correct_total;
    logic [23:0] sample_total;

    modport source (output valid, predicted_class, is_correct, correct_total,
                    sample_total, input ready);
    modport sink (input valid, predicted_class, is_correct, correct_total,
                  sample_total, output ready);
endinterface

[design/slca_ram.sv]
// ============================================================================
// slca_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module slca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/slca_front.sv]
// ============================================================================
// slca_front
// Accepts input beats, classifies them and pushes commands into a queue.
// ============================================================================
module slca_front #(
    parameter int NUM_FEATURES = slca_pkg::NUM_FEATURES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    slca_in_if.sink              i_in,
    input  logic                 i_pop,
    output logic                 o_qvalid,
    output slca_pkg::t_cmd       o_cmd
);
    localparam int PW = $clog2(slca_pkg::QDEPTH);

    slca_pkg::t_cmd  r_q [slca_pkg::QDEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    slca_pkg::t_cmd  n_cmd;
    logic            push;

    assign i_in.ready = (r_cnt != (PW+1)'(slca_pkg::QDEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign o_qvalid   = (r_cnt != '0);
    assign o_cmd      = r_q[r_rp];

    always_comb begin
        n_cmd.op      = slca_pkg::t_op'(i_in.operation);
        n_cmd.feat_ok = (32'(i_in.feature_index) < NUM_FEATURES);
        n_cmd.feat    = i_in.feature_index;
        n_cmd.cls     = i_in.class_index;
        n_cmd.wval    = i_in.weight_value;
        n_cmd.fval    = i_in.feature_value;
        n_cmd.label   = i_in.label;
        n_cmd.last    = i_in.last_feature;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(i_pop);
        end
    end
endmodule

[design/slca_back.sv]
// ============================================================================
// slca_back
// Executes commands: weight writes, per-class MAC sweep, argmax, counters.
// ============================================================================
module slca_back #(
    parameter int NUM_FEATURES = slca_pkg::NUM_FEATURES_DEF,
    parameter int NUM_CLASSES  = slca_pkg::NUM_CLASSES_DEF,
    parameter int VALUE_BITS   = slca_pkg::VALUE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [slca_pkg::CFG_W-1:0]     i_classes,
    input  logic                           i_qvalid,
    input  slca_pkg::t_cmd                 i_cmd,
    output logic                           o_pop,
    output logic                           o_busy,
    slca_out_if.source                     o_out
);
    localparam int CW   = $clog2(NUM_CLASSES);
    localparam int FW   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int AW   = $clog2(NUM_FEATURES * NUM_CLASSES);
    localparam int PW   = 2 * VALUE_BITS;
    localparam int SW   = slca_pkg::SCORE_W;
    localparam int NW   = CW + 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MAC  = 5'b00010,
        ST_ARG  = 5'b00100,
        ST_OUT  = 5'b01000,
        ST_WAIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // active class count, clamped
    logic [NW-1:0] act_n;
    always_comb begin
        if (i_classes == '0) act_n = NW'(1);
        else if (32'(i_classes) > NUM_CLASSES) act_n = NW'(NUM_CLASSES);
        else act_n = NW'(i_classes);
    end

    // weight memory
    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [VALUE_BITS-1:0] rdata;
    logic [NW-1:0]         r_cls;
    slca_pkg::t_cmd        r_cmd;

    assign we = o_pop && (i_cmd.op == slca_pkg::OP_WRITE) && i_cmd.feat_ok
                && (32'(i_cmd.cls) < NUM_CLASSES);
    assign waddr = AW'(FW'(i_cmd.feat) * NUM_CLASSES + CW'(i_cmd.cls));
    assign raddr = AW'(FW'(r_cmd.feat) * NUM_CLASSES + CW'(r_cls));

    slca_ram #(.WIDTH(VALUE_BITS), .DEPTH(NUM_FEATURES * NUM_CLASSES)) u_wmem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(VALUE_BITS'(i_cmd.wval)),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // MAC pipeline: read, then multiply, then accumulate
    logic                 r_rd_v, r_mul_v;
    logic [CW-1:0]        r_rd_c, r_mul_c;
    logic signed [PW-1:0] r_prod;
    logic signed [SW-1:0] r_score [NUM_CLASSES];

    localparam logic signed [SW:0] HI = (SW+1)'({1'b0, {(SW-1){1'b1}}});
    localparam logic signed [SW:0] LO = -HI - 1;
    logic signed [SW:0] sum;
    assign sum = (SW+1)'(r_score[r_mul_c]) + (SW+1)'(r_prod);

    // argmax sweep
    logic [NW-1:0]        r_ai;
    logic [CW-1:0]        r_best;
    logic signed [SW-1:0] r_bscore;

    logic [slca_pkg::CNT_W-1:0] r_ccnt, r_scnt, n_ccnt, n_scnt;
    logic [slca_pkg::CNT_W-1:0] r_octot, r_ostot;
    logic                       r_ovalid;
    logic [3:0]                 r_opred;
    logic                       r_ohit;

    logic mac_done;
    assign mac_done = !r_rd_v && !r_mul_v;
    assign o_busy   = !(r_state == ST_IDLE);
    assign o_pop    = (r_state == ST_IDLE) && i_qvalid;

    logic hit;
    assign hit = (CW'(r_best) == CW'(r_cmd.label)) && (32'(r_cmd.label) < NUM_CLASSES)
                 && (4'(r_best) == r_cmd.label);

    // counters after this sample, saturating
    assign n_scnt = (r_scnt != slca_pkg::CNT_MAX) ? r_scnt + 1'b1 : r_scnt;
    assign n_ccnt = (hit && r_ccnt != slca_pkg::CNT_MAX) ? r_ccnt + 1'b1 : r_ccnt;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop && i_cmd.op == slca_pkg::OP_SAMPLE) begin
                    n_state = i_cmd.feat_ok ? ST_MAC : (i_cmd.last ? ST_ARG : ST_IDLE);
                end
            end
            ST_MAC:  if (r_cls == act_n) n_state = ST_WAIT;
            ST_WAIT: if (mac_done) n_state = r_cmd.last ? ST_ARG : ST_IDLE;
            ST_ARG:  if (r_ai == act_n) n_state = ST_OUT;
            ST_OUT:  if (!r_ovalid || o_out.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cmd <= i_cmd;
        r_prod  <= $signed(rdata) * $signed(VALUE_BITS'(r_cmd.fval));
        r_rd_c  <= CW'(r_cls);
        r_mul_c <= r_rd_c;
        if (r_state == ST_OUT && n_state == ST_IDLE) begin
            r_opred <= 4'(r_best);
            r_ohit  <= hit;
            r_octot <= n_ccnt;
            r_ostot <= n_scnt;
        end
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cls    <= '0;
            r_rd_v   <= 1'b0;
            r_mul_v  <= 1'b0;
            r_ai     <= '0;
            r_best   <= '0;
            r_bscore <= '0;
            r_ccnt   <= '0;
            r_scnt   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) r_score[i] <= '0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= (r_state == ST_MAC) && (r_cls != act_n);
            r_mul_v <= r_rd_v;
            if (o_pop) r_cls <= '0;
            else if (r_state == ST_MAC && r_cls != act_n) r_cls <= r_cls + 1'b1;
            if (r_mul_v) begin
                if (sum > HI) r_score[r_mul_c] <= SW'(HI);
                else if (sum < LO) r_score[r_mul_c] <= SW'(LO);
                else r_score[r_mul_c] <= SW'(sum);
            end
            if (o_pop && i_cmd.op == slca_pkg::OP_CLEAR) begin
                r_ccnt <= '0;
                r_scnt <= '0;
            end
            if (n_state == ST_ARG && r_state != ST_ARG) begin
                r_ai     <= NW'(1);
                r_best   <= '0;
                r_bscore <= r_score[0];
            end else if (r_state == ST_ARG && r_ai != act_n) begin
                if (r_score[CW'(r_ai)] > r_bscore) begin
                    r_best   <= CW'(r_ai);
                    r_bscore <= r_score[CW'(r_ai)];
                end
                r_ai <= r_ai + 1'b1;
            end
            if (r_state == ST_OUT && n_state == ST_IDLE) begin
                r_ovalid <= 1'b1;
                r_scnt   <= n_scnt;
                r_ccnt   <= n_ccnt;
                for (int i = 0; i < NUM_CLASSES; i++) r_score[i] <= '0;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.predicted_class = r_opred;
    assign o_out.is_correct      = r_ohit;
    assign o_out.correct_total   = r_octot;
    assign o_out.sample_total    = r_ostot;
endmodule

[design/sparse_linear_classifier_accuracy_top.sv]
// ============================================================================
// sparse_linear_classifier_accuracy_top
// Sparse multiclass linear classifier with argmax and accuracy counters.
// ============================================================================
// A front stage takes input beats into a two-entry command queue; a back
// stage executes them. A weight write or counter clear is carried out as
// it is popped. A sample feature pops its command; then one shared
// multiplier sweeps the N clamped classes through the weight memory's
// single read port, and the read/multiply/accumulate pipeline drains.
// The last feature adds an argmax sweep over the N classes and a load of
// the result register; that load waits while a previous result is still
// held. The result register decouples the output, and the counters it
// reports are the values after this sample. No memory clearing pass is
// needed.
module sparse_linear_classifier_accuracy_top #(
    parameter int NUM_FEATURES = slca_pkg::NUM_FEATURES_DEF,
    parameter int NUM_CLASSES  = slca_pkg::NUM_CLASSES_DEF,
    parameter int VALUE_BITS   = slca_pkg::VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [slca_pkg::CFG_W-1:0] i_cfg_wdata,
    slca_in_if.sink                    i_in,
    slca_out_if.source                 o_out
);
    logic [slca_pkg::CFG_W-1:0] r_classes;
    logic                       qvalid, pop, busy;
    slca_pkg::t_cmd             cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_classes <= slca_pkg::CLASSES_RESET;
        else if (i_cfg_we) r_classes <= i_cfg_wdata;
    end

    slca_front #(.NUM_FEATURES(NUM_FEATURES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .i_pop(pop), .o_qvalid(qvalid), .o_cmd(cmd)
    );

    slca_back #(.NUM_FEATURES(NUM_FEATURES), .NUM_CLASSES(NUM_CLASSES),
                .VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_classes(r_classes),
        .i_qvalid(qvalid), .i_cmd(cmd), .o_pop(pop), .o_busy(busy),
        .o_out(o_out)
    );

`ifndef SYNTHESIS
    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> qvalid) else $error("pop from empty queue");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !pop) else $error("pop while back end busy");
    a_sat_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.correct_total <= o_out.sample_total))
        else $error("correct count exceeds sample count");
`endif
endmodule

[test/tb_sparse_linear_classifier_accuracy_top.sv]
// ============================================================================
// tb_sparse_linear_classifier_accuracy_top
// Checks the sparse classifier beat by beat against a behavioral predictor.
// It loads the weights, runs directed and random samples under several
// class counts, and applies random stalls plus one long output hold-off.
// ============================================================================
module tb_sparse_linear_classifier_accuracy_top;
    timeunit 1ns;
    timeprecision 1ps;
    import slca_pkg::*;

    localparam int IDLE_LIMIT = 20000;  // cycles with no beat before giving up
    localparam int SETTLE     = 80;     // > one full sample sweep plus queue

    typedef struct packed {
        logic [3:0]  cls;
        logic        hit;
        logic [23:0] n_correct;
        logic [23:0] n_samples;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    slca_in_if  in_ch ();
    slca_out_if out_ch ();

    sparse_linear_classifier_accuracy_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Predictor state: the block as software sees it.
    logic signed [15:0] weights [NUM_FEATURES_DEF][NUM_CLASSES_DEF];
    longint             scores  [NUM_CLASSES_DEF];
    logic [CNT_W-1:0]   correct_cnt, sample_cnt;
    logic [CFG_W-1:0]   class_cfg;
    t_verdict           verdicts_due [$];

    int  fails;
    int  idle_cycles;
    bit  no_gaps;       // phases without sender idling
    bit  hold_req;      // asks the hold-off process for a long output stall
    bit  hold_active;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void predict_beat(t_op op, logic [9:0] feat, logic [3:0] cls,
                                         logic signed [15:0] wv, logic signed [15:0] fv,
                                         logic [3:0] label, logic last);
        longint   hi;
        longint   sum;
        int       n;
        int       best;
        t_verdict v;
        hi = (longint'(1) <<< (SCORE_W - 1)) - 1;
        n  = (class_cfg == 0) ? 1 : (class_cfg > NUM_CLASSES_DEF) ? NUM_CLASSES_DEF
                                                                  : int'(class_cfg);
        case (op)
            OP_WRITE: weights[feat][cls] = wv;
            OP_CLEAR: begin
                correct_cnt = '0;
                sample_cnt  = '0;
            end
            OP_SAMPLE: begin
                for (int c = 0; c < n; c++) begin
                    sum = scores[c] + longint'(weights[feat][c]) * longint'(fv);
                    scores[c] = (sum > hi) ? hi : (sum < -hi - 1) ? -hi - 1 : sum;
                end
                if (last) begin
                    best = 0;
                    for (int c = 1; c < n; c++)
                        if (scores[c] > scores[best]) best = c;
                    v.cls = best[3:0];
                    v.hit = (best == int'(label));
                    if (sample_cnt != CNT_MAX) sample_cnt++;
                    if (v.hit && correct_cnt != CNT_MAX) correct_cnt++;
                    v.n_correct = correct_cnt;
                    v.n_samples = sample_cnt;
                    verdicts_due.push_back(v);
                    foreach (scores[c]) scores[c] = 0;
                end
            end
            default: ;  // unused code, ignored
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            t_verdict got;
            t_verdict want;
            got = {out_ch.predicted_class, out_ch.is_correct,
                   out_ch.correct_total, out_ch.sample_total};
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected result beat %p", $time, got);
                fails++;
            end else begin
                want = verdicts_due.pop_front();
                if (got.cls !== want.cls) begin
                    $display("%0t: predicted_class exp %0d got %0d", $time, want.cls, got.cls);
                    fails++;
                end
                if (got.hit !== want.hit) begin
                    $display("%0t: is_correct exp %0d got %0d", $time, want.hit, got.hit);
                    fails++;
                end
                if (got.n_correct !== want.n_correct) begin
                    $display("%0t: correct_total exp %0d got %0d", $time,
                             want.n_correct, got.n_correct);
                    fails++;
                end
                if (got.n_samples !== want.n_samples) begin
                    $display("%0t: sample_total exp %0d got %0d", $time,
                             want.n_samples, got.n_samples);
                    fails++;
                end
            end
        end
    end

    // Watchdog: any beat on either side restarts the count.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("tb_sparse_linear_classifier_accuracy_top NOT OK");
            $finish;
        end
    end

    // Long output hold-off, counted here while the sender keeps pushing.
    initial begin
        hold_active = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_active = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_active = 1'b0;
                hold_req    = 1'b0;
            end
        end
    end

    // Output ready: mostly open, short stalls, a few long ones.
    initial begin
        int stall;
        int r;
        stall = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_active) begin
                out_ch.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 15)      stall = $urandom_range(1, 3);
                else if (r < 18) stall = $urandom_range(10, 40);
                out_ch.ready <= (stall == 0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Features that hold fully written weights: 0..15 and the top one.
    function automatic logic [9:0] pick_feature();
        int k;
        k = $urandom_range(0, 16);
        return (k == 16) ? 10'd1023 : 10'(k);
    endfunction

    // Valid stays high between back-to-back beats; it only drops for a gap.
    task automatic send_beat(t_op op, logic [9:0] feat, logic [3:0] cls,
                             logic signed [15:0] wv, logic signed [15:0] fv,
                             logic [3:0] label, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= op;
        in_ch.feature_index <= feat;
        in_ch.class_index   <= cls;
        in_ch.weight_value  <= wv;
        in_ch.feature_value <= fv;
        in_ch.label         <= label;
        in_ch.last_feature  <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_beat(op, feat, cls, wv, fv, label, last);
    endtask

    task automatic send_sample(int len, logic [3:0] label);
        for (int k = 0; k < len; k++)
            send_beat(OP_SAMPLE, pick_feature(), 4'($urandom), 16'($urandom),
                      16'($urandom), label, k == len - 1);
    endtask

    // Register writes only once the block has gone quiet.
    task automatic set_classes(logic [CFG_W-1:0] value);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (verdicts_due.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        class_cfg    = value;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_weight_load();
        for (int f = 0; f <= 16; f++)
            for (int c = 0; c < NUM_CLASSES_DEF; c++)
                send_beat(OP_WRITE, (f == 16) ? 10'd1023 : 10'(f), 4'(c),
                          16'($urandom), 16'($urandom), 4'($urandom), 1'($urandom));
    endtask

    task automatic test_directed();
        // extreme weights on the top feature, extreme values against them
        send_beat(OP_WRITE, 10'd1023, 4'd0, -16'sd32768, 16'sd0, 4'd0, 1'b0);
        send_beat(OP_WRITE, 10'd1023, 4'd15, 16'sd32767, 16'sd0, 4'd15, 1'b1);
        send_beat(OP_SAMPLE, 10'd1023, 4'd0, 16'sd0, -16'sd32768, 4'd0, 1'b1);
        send_beat(OP_SAMPLE, 10'd1023, 4'd15, 16'sd0, 16'sd32767, 4'd15, 1'b1);
        send_beat(OP_SAMPLE, 10'd1023, 4'd0, 16'sd0, -16'sd32768, 4'd0, 1'b0);
        send_beat(OP_SAMPLE, 10'd1023, 4'd0, 16'sd0, -16'sd32768, 4'd15, 1'b1);
        // empty sample: one zero-valued beat, class 0 wins
        send_beat(OP_SAMPLE, 10'd3, 4'd0, 16'sd0, 16'sd0, 4'd0, 1'b1);
        send_beat(OP_SAMPLE, 10'd0, 4'd0, 16'sd0, 16'sd0, 4'd9, 1'b1);
        // equal weights on feature 14: tie resolves to the lowest class
        for (int c = 0; c < NUM_CLASSES_DEF; c++)
            send_beat(OP_WRITE, 10'd14, 4'(c), 16'sd100, 16'sd0, 4'd0, 1'b0);
        send_beat(OP_SAMPLE, 10'd14, 4'd0, 16'sd0, 16'sd4096, 4'd0, 1'b1);
        // unused code, then a clear of the counters mid-sample
        send_beat(OP_NONE, 10'd1023, 4'd15, -16'sd1, -16'sd1, 4'd15, 1'b1);
        send_beat(OP_SAMPLE, 10'd1, 4'd0, 16'sd0, 16'sd2048, 4'd2, 1'b0);
        send_beat(OP_CLEAR, 10'd0, 4'd0, 16'sd0, 16'sd0, 4'd0, 1'b1);
        send_beat(OP_SAMPLE, 10'd2, 4'd0, 16'sd0, -16'sd1, 4'd2, 1'b1);
    endtask

    task automatic test_class_counts();
        logic [CFG_W-1:0] counts [6] = '{5'd0, 5'd1, 5'd31, 5'd2, 5'd17, 5'd7};
        foreach (counts[i]) begin
            set_classes(counts[i]);
            repeat (8) send_sample($urandom_range(1, 4), 4'($urandom));
        end
        set_classes(5'd16);
    endtask

    task automatic test_random_traffic(int beats);
        int sent;
        int r;
        int len;
        sent = 0;
        while (sent < beats) begin
            no_gaps = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < 75) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                  : $urandom_range(1, 5);
                send_sample(len, 4'($urandom));
                sent += len;
            end else begin
                if (r < 92)
                    send_beat(OP_WRITE, pick_feature(), 4'($urandom), 16'($urandom),
                              16'($urandom), 4'($urandom), 1'($urandom));
                else if (r < 96)
                    send_beat(OP_CLEAR, 10'($urandom), 4'($urandom), 16'($urandom),
                              16'($urandom), 4'($urandom), 1'($urandom));
                else
                    send_beat(OP_NONE, 10'($urandom), 4'($urandom), 16'($urandom),
                              16'($urandom), 4'($urandom), 1'($urandom));
                sent++;
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_output_hold();
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        repeat (20) send_sample($urandom_range(1, 3), 4'($urandom));
        no_gaps  = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        fails       = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        hold_req    = 1'b0;
        correct_cnt = '0;
        sample_cnt  = '0;
        class_cfg   = CLASSES_RESET;
        foreach (scores[c]) scores[c] = 0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        in_ch.valid         = 1'b0;
        in_ch.operation     = OP_NONE;
        in_ch.feature_index = '0;
        in_ch.class_index   = '0;
        in_ch.weight_value  = '0;
        in_ch.feature_value = '0;
        in_ch.label         = '0;
        in_ch.last_feature  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_weight_load();
        test_directed();
        test_class_counts();
        test_output_hold();
        test_random_traffic(1000);

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (verdicts_due.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (fails == 0)
            $display("tb_sparse_linear_classifier_accuracy_top OK");
        else
            $display("tb_sparse_linear_classifier_accuracy_top NOT OK");
        $finish;
    end
endmodule
